// File: hw/rtl/triangle_coverage_rasterizer_assert.svh
// Assertion macros for the triangle coverage rasterizer.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef TRIANGLE_COVERAGE_RASTERIZER_ASSERT_SVH
`define TRIANGLE_COVERAGE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rasterizer check failed");

// Next-cycle implication, checked outside reset.
`define TCR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rasterizer check failed");

`endif

// File: hw/rtl/tcr_pkg.sv
// Shared constants, types and command/status structs of the triangle coverage rasterizer.
// No dependencies; used by tcr_ctrl, tcr_datapath and the top level.
package tcr_pkg;

	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 200;
	localparam int NUM_PIXELS    = SCREEN_WIDTH * SCREEN_HEIGHT;

	// Field widths fixed by the interface.
	localparam int COORD_W = 12;
	localparam int RDX_W   = 9;
	localparam int RDY_W   = 8;
	localparam int CNT_W   = 16;

	// Internal widths.
	localparam int X_W     = $clog2(SCREEN_WIDTH);
	localparam int Y_W     = $clog2(SCREEN_HEIGHT);
	localparam int ADDR_W  = $clog2(NUM_PIXELS);
	localparam int DELTA_W = COORD_W + 1;
	localparam int PROD_W  = 2 * DELTA_W;
	localparam int ACC_W   = PROD_W + 2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DELTA_W-1:0] delta_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	// Product schedule of the setup multiplier.
	localparam int MUL_SEL_W = 3;
	localparam logic [MUL_SEL_W-1:0] MS_AREA_A = 3'd0;
	localparam logic [MUL_SEL_W-1:0] MS_AREA_B = 3'd1;
	localparam logic [MUL_SEL_W-1:0] MS_W0_A   = 3'd2;
	localparam logic [MUL_SEL_W-1:0] MS_W0_B   = 3'd3;
	localparam logic [MUL_SEL_W-1:0] MS_W1_A   = 3'd4;
	localparam logic [MUL_SEL_W-1:0] MS_W1_B   = 3'd5;
	localparam logic [MUL_SEL_W-1:0] MS_W2_A   = 3'd6;
	localparam logic [MUL_SEL_W-1:0] MS_W2_B   = 3'd7;
	localparam logic [MUL_SEL_W-1:0] MS_FIRST  = MS_AREA_A;
	localparam logic [MUL_SEL_W-1:0] MS_LAST   = MS_W2_B;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                 load;
		logic                 box;
		logic                 offs;
		logic                 mul_en;
		logic [MUL_SEL_W-1:0] mul_sel;
		logic                 walk_init;
		logic                 walk_en;
		logic                 clear_en;
		logic                 rd_en;
		logic                 res_load;
	} tcr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic area_zero;
		logic box_empty;
		logic walk_last;
	} tcr_stat_t;

endpackage

// File: hw/rtl/triangle_coverage_rasterizer.sv
// A read is looked up in S_READ and its result is loaded in S_DONE; a draw runs setup
// (box, offsets, eight products on one shared multiplier), then walks the clamped
// bounding box one pixel per cycle, so throughput is set by the pixel walk.
// One item is in work at a time; the result register lets the next beat in while it waits.
// Reset is asynchronous, active low; afterwards the frame store is swept clear one pixel
// a cycle (SCREEN_WIDTH * SCREEN_HEIGHT = 64000 pixels) before the first beat is taken.
`include "triangle_coverage_rasterizer_assert.svh"

module triangle_coverage_rasterizer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      cmd,
	input  tcr_pkg::coord_t           ax,
	input  tcr_pkg::coord_t           ay,
	input  tcr_pkg::coord_t           bx,
	input  tcr_pkg::coord_t           by_coord,
	input  tcr_pkg::coord_t           cx,
	input  tcr_pkg::coord_t           cy,
	input  logic [tcr_pkg::RDX_W-1:0] read_x,
	input  logic [tcr_pkg::RDY_W-1:0] read_y,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      pixel_value,
	output logic [tcr_pkg::CNT_W-1:0] covered_count,
	output logic                      degenerate
);
	import tcr_pkg::*;

	tcr_cmd_t  dp_cmd;
	tcr_stat_t dp_stat;

	// Sequencer.
	tcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.read_cmd  (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (dp_cmd),
		.stat      (dp_stat)
	);

	// Arithmetic, walk and frame store.
	tcr_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dp_cmd),
		.stat          (dp_stat),
		.ax            (ax),
		.ay            (ay),
		.bx            (bx),
		.by_coord      (by_coord),
		.cx            (cx),
		.cy            (cy),
		.read_x        (read_x),
		.read_y        (read_y),
		.read_cmd      (cmd),
		.pixel_value   (pixel_value),
		.covered_count (covered_count),
		.degenerate    (degenerate)
	);

	// Only one item is in work: no beat is taken right after one is accepted.
	`TCR_ASSERT_NXT(a_one_in_work, in_valid && in_ready, !in_ready)
	// A loaded result is presented in the next cycle.
	`TCR_ASSERT_NXT(a_result_shown, dp_cmd.res_load, out_valid)
	// A set pixel only comes from a read, which carries no count and no flag.
	`TCR_ASSERT_IMP(a_read_fields, out_valid && pixel_value, covered_count == '0 && !degenerate)
	// A skipped draw reports no covered pixels.
	`TCR_ASSERT_IMP(a_degenerate_empty, out_valid && degenerate, covered_count == '0)

endmodule

// File: hw/rtl/tcr_ctrl.sv
// Controller state machine of the triangle coverage rasterizer.
// Depends on tcr_pkg; drives tcr_datapath through tcr_cmd_t and reads tcr_stat_t.
module tcr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              read_cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output tcr_pkg::tcr_cmd_t cmd,
	input  tcr_pkg::tcr_stat_t stat
);
	import tcr_pkg::*;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_BOX   = 4'd2;
	localparam logic [3:0] S_OFFS  = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_DRAIN = 4'd5;
	localparam logic [3:0] S_CHECK = 4'd6;
	localparam logic [3:0] S_WALK  = 4'd7;
	localparam logic [3:0] S_READ  = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0]           state_q, state_d;
	logic [MUL_SEL_W-1:0] step_q;
	logic                 out_valid_q;
	logic                 res_take;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	// The result register is free when empty or being drained this cycle.
	assign res_take  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Next state and commands.
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.mul_sel   = step_q;
		cmd.res_load  = res_take;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = read_cmd ? S_READ : S_BOX;
				end
			end
			S_BOX: begin
				cmd.box = 1'b1;
				state_d = S_OFFS;
			end
			S_OFFS: begin
				cmd.offs = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				if (step_q == MS_LAST) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				cmd.walk_init = 1'b1;
				if (stat.area_zero || stat.box_empty) begin
					state_d = S_DONE;
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk_en = 1'b1;
				if (stat.walk_last) begin
					state_d = S_DONE;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, product step counter and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			step_q      <= MS_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OFFS) begin
				step_q <= MS_FIRST;
			end else if (state_q == S_MUL) begin
				step_q <= step_q + 1'b1;
			end
			if (res_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/tcr_datapath.sv
// Datapath of the triangle coverage rasterizer: bounding box, edge function setup,
// incremental pixel walk, frame store memory and result register. Depends on tcr_pkg.
module tcr_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcr_pkg::tcr_cmd_t           cmd,
	output tcr_pkg::tcr_stat_t          stat,
	input  tcr_pkg::coord_t             ax,
	input  tcr_pkg::coord_t             ay,
	input  tcr_pkg::coord_t             bx,
	input  tcr_pkg::coord_t             by_coord,
	input  tcr_pkg::coord_t             cx,
	input  tcr_pkg::coord_t             cy,
	input  logic [tcr_pkg::RDX_W-1:0]   read_x,
	input  logic [tcr_pkg::RDY_W-1:0]   read_y,
	input  logic                        read_cmd,
	output logic                        pixel_value,
	output logic [tcr_pkg::CNT_W-1:0]   covered_count,
	output logic                        degenerate
);
	import tcr_pkg::*;

	localparam coord_t MAX_X = coord_t'(SCREEN_WIDTH - 1);
	localparam coord_t MAX_Y = coord_t'(SCREEN_HEIGHT - 1);
	localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(SCREEN_WIDTH);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_PIXELS - 1);
	localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

	// Frame store.
	logic mem [NUM_PIXELS];

	coord_t ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	coord_t minx_q, maxx_q, miny_q, maxy_q;
	delta_t e0x_q, e0y_q, e1x_q, e1y_q, e2x_q, e2y_q;
	delta_t oax_q, oay_q, obx_q, oby_q, ocx_q, ocy_q;
	logic [ADDR_W-1:0] rd_addr_q, row_addr_q, row_base_q, addr_q;
	logic              rd_ok_q, is_read_q, deg_q, rdata_q;
	prod_t             prod_s1;
	logic [MUL_SEL_W-1:0] sel_s1;
	logic              valid_s1;
	acc_t              area_q, row0_q, row1_q, row2_q, w0_q, w1_q, w2_q;
	logic [X_W-1:0]    x_q;
	logic [Y_W-1:0]    y_q;
	logic [CNT_W-1:0]  count_q;

	coord_t minx_c, maxx_c, miny_c, maxy_c;
	delta_t mul_a, mul_b;
	logic   pix_hit, x_last, y_last, mem_we, mem_wd;

	function automatic coord_t min3(input coord_t p, input coord_t q, input coord_t r);
		coord_t m;
		m = p;
		if (q < m) m = q;
		if (r < m) m = r;
		return m;
	endfunction

	function automatic coord_t max3(input coord_t p, input coord_t q, input coord_t r);
		coord_t m;
		m = p;
		if (q > m) m = q;
		if (r > m) m = r;
		return m;
	endfunction

	// Vertex bounding box clamped to the screen.
	always_comb begin
		minx_c = min3(ax_q, bx_q, cx_q);
		maxx_c = max3(ax_q, bx_q, cx_q);
		miny_c = min3(ay_q, by_q, cy_q);
		maxy_c = max3(ay_q, by_q, cy_q);
		if (minx_c < 0) minx_c = '0;
		if (miny_c < 0) miny_c = '0;
		if (maxx_c > MAX_X) maxx_c = MAX_X;
		if (maxy_c > MAX_Y) maxy_c = MAX_Y;
	end

	// Operand selection for the shared setup multiplier.
	always_comb begin
		case (cmd.mul_sel)
			MS_AREA_A: begin mul_a = e2y_q; mul_b = e1x_q; end
			MS_AREA_B: begin mul_a = e2x_q; mul_b = e1y_q; end
			MS_W0_A:   begin mul_a = e0x_q; mul_b = oby_q; end
			MS_W0_B:   begin mul_a = e0y_q; mul_b = obx_q; end
			MS_W1_A:   begin mul_a = e1x_q; mul_b = ocy_q; end
			MS_W1_B:   begin mul_a = e1y_q; mul_b = ocx_q; end
			MS_W2_A:   begin mul_a = e2x_q; mul_b = oay_q; end
			MS_W2_B:   begin mul_a = e2y_q; mul_b = oax_q; end
			default:   begin mul_a = '0;    mul_b = '0;    end
		endcase
	end

	// Pixel test: inside for either winding.
	assign pix_hit = ((w0_q >= 0) && (w1_q >= 0) && (w2_q >= 0)) ||
	                 ((w0_q <= 0) && (w1_q <= 0) && (w2_q <= 0));
	assign x_last = (x_q == minx_q[X_W-1:0]) ? (minx_q == maxx_q) : (x_q == maxx_q[X_W-1:0]);
	assign y_last = (y_q == maxy_q[Y_W-1:0]);

	assign stat.clear_last = (addr_q == LAST_ADDR);
	assign stat.area_zero  = (area_q == '0);
	assign stat.box_empty  = (minx_q > maxx_q) || (miny_q > maxy_q);
	assign stat.walk_last  = x_last && y_last;

	assign mem_we = cmd.clear_en || (cmd.walk_en && pix_hit);
	assign mem_wd = cmd.walk_en;

	// Frame store write and registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= mem_wd;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr_q];
		end
	end

	// Write address: clearing sweep after reset, then the pixel walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.clear_en) begin
			addr_q <= addr_q + 1'b1;
		end else if (cmd.walk_init) begin
			addr_q <= row_addr_q;
		end else if (cmd.walk_en) begin
			if (x_last) begin
				addr_q <= row_base_q + ROW_STEP;
			end else begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	// Setup product valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.mul_en;
		end
	end

	// Operand capture, box, deltas and offsets.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q      <= ax;
			ay_q      <= ay;
			bx_q      <= bx;
			by_q      <= by_coord;
			cx_q      <= cx;
			cy_q      <= cy;
			is_read_q <= read_cmd;
			rd_ok_q   <= (int'(read_x) < SCREEN_WIDTH) && (int'(read_y) < SCREEN_HEIGHT);
			rd_addr_q <= ADDR_W'(read_y) * ROW_STEP + ADDR_W'(read_x);
		end
		if (cmd.box) begin
			minx_q <= minx_c;
			maxx_q <= maxx_c;
			miny_q <= miny_c;
			maxy_q <= maxy_c;
			e0x_q  <= DELTA_W'(cx_q) - DELTA_W'(bx_q);
			e0y_q  <= DELTA_W'(cy_q) - DELTA_W'(by_q);
			e1x_q  <= DELTA_W'(ax_q) - DELTA_W'(cx_q);
			e1y_q  <= DELTA_W'(ay_q) - DELTA_W'(cy_q);
			e2x_q  <= DELTA_W'(bx_q) - DELTA_W'(ax_q);
			e2y_q  <= DELTA_W'(by_q) - DELTA_W'(ay_q);
		end
		if (cmd.offs) begin
			oax_q      <= DELTA_W'(minx_q) - DELTA_W'(ax_q);
			oay_q      <= DELTA_W'(miny_q) - DELTA_W'(ay_q);
			obx_q      <= DELTA_W'(minx_q) - DELTA_W'(bx_q);
			oby_q      <= DELTA_W'(miny_q) - DELTA_W'(by_q);
			ocx_q      <= DELTA_W'(minx_q) - DELTA_W'(cx_q);
			ocy_q      <= DELTA_W'(miny_q) - DELTA_W'(cy_q);
			row_addr_q <= ADDR_W'(miny_q[Y_W-1:0]) * ROW_STEP + ADDR_W'(minx_q[X_W-1:0]);
		end
	end

	// Setup multiplier stage, accumulation of area and corner edge values, and row stepping.
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		sel_s1  <= cmd.mul_sel;
		if (cmd.offs) begin
			area_q <= '0;
			row0_q <= '0;
			row1_q <= '0;
			row2_q <= '0;
		end else if (valid_s1) begin
			case (sel_s1)
				MS_AREA_A: area_q <= area_q + ACC_W'(prod_s1);
				MS_AREA_B: area_q <= area_q - ACC_W'(prod_s1);
				MS_W0_A:   row0_q <= row0_q + ACC_W'(prod_s1);
				MS_W0_B:   row0_q <= row0_q - ACC_W'(prod_s1);
				MS_W1_A:   row1_q <= row1_q + ACC_W'(prod_s1);
				MS_W1_B:   row1_q <= row1_q - ACC_W'(prod_s1);
				MS_W2_A:   row2_q <= row2_q + ACC_W'(prod_s1);
				MS_W2_B:   row2_q <= row2_q - ACC_W'(prod_s1);
				default:   area_q <= area_q;
			endcase
		end else if (cmd.walk_en && x_last) begin
			row0_q <= row0_q + ACC_W'(e0x_q);
			row1_q <= row1_q + ACC_W'(e1x_q);
			row2_q <= row2_q + ACC_W'(e2x_q);
		end
	end

	// Pixel walk: step edge values along x, and along y at the end of a row.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			count_q <= '0;
		end else if (cmd.walk_en && pix_hit && (count_q != CNT_MAX)) begin
			count_q <= count_q + 1'b1;
		end
		if (cmd.walk_init) begin
			deg_q      <= stat.area_zero;
			w0_q       <= row0_q;
			w1_q       <= row1_q;
			w2_q       <= row2_q;
			x_q        <= minx_q[X_W-1:0];
			y_q        <= miny_q[Y_W-1:0];
			row_base_q <= row_addr_q;
		end else if (cmd.walk_en) begin
			if (x_last) begin
				w0_q       <= row0_q + ACC_W'(e0x_q);
				w1_q       <= row1_q + ACC_W'(e1x_q);
				w2_q       <= row2_q + ACC_W'(e2x_q);
				x_q        <= minx_q[X_W-1:0];
				y_q        <= y_q + 1'b1;
				row_base_q <= row_base_q + ROW_STEP;
			end else begin
				w0_q <= w0_q - ACC_W'(e0y_q);
				w1_q <= w1_q - ACC_W'(e1y_q);
				w2_q <= w2_q - ACC_W'(e2y_q);
				x_q  <= x_q + 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			pixel_value   <= is_read_q && rd_ok_q && rdata_q;
			covered_count <= is_read_q ? '0 : count_q;
			degenerate    <= !is_read_q && deg_q;
		end
	end

endmodule
